>>> rtl/tfpr_pkg.sv
`timescale 1ns / 1ps

package tfpr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAC_DIGIT      = 8;
    localparam int SCALE_BITS     = 16;
    localparam int CENTER_BITS    = 17;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_MOVE  = 2'd1;

    localparam logic [2:0] ACT_IGNORE  = 3'd0;
    localparam logic [2:0] ACT_MAYBE   = 3'd1;
    localparam logic [2:0] ACT_CANCEL  = 3'd2;
    localparam logic [2:0] ACT_TRIGGER = 3'd3;
    localparam logic [2:0] ACT_FINISH  = 3'd4;

    localparam logic [1:0] GS_NONE     = 2'd0;
    localparam logic [1:0] GS_STARTED  = 2'd1;
    localparam logic [1:0] GS_UPDATED  = 2'd2;
    localparam logic [1:0] GS_FINISHED = 2'd3;

    localparam logic [0:0] CFG_MIN_COSINE = 1'd0;
    localparam logic [0:0] CFG_MIN_MOVE   = 1'd1;

    localparam logic [15:0] MIN_COSINE_RST = 16'd32768;
    localparam logic [31:0] MIN_MOVE_RST   = 32'd100;

    // accumulator: dot^2 * 2^32 and m2 * a2 * cos^2 plus a sign bit
    function automatic int acc_bits(input int cw);
        return 4 * cw + 35;
    endfunction

    function automatic int mul_b_bits(input int cw);
        return (2 * cw + 2 > 32) ? 2 * cw + 2 : 32;
    endfunction

endpackage

>>> rtl/tfpr_mac.sv
`timescale 1ns / 1ps

module tfpr_mac #(
    parameter int CW = tfpr_pkg::COORD_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   clr,
    input  logic                                   neg,
    input  logic [tfpr_pkg::acc_bits(CW)-1:0]      a,
    input  logic [tfpr_pkg::mul_b_bits(CW)-1:0]    b,
    output logic                                   busy,
    output logic [tfpr_pkg::acc_bits(CW)-1:0]      acc
);
    import tfpr_pkg::*;

    localparam int DW = acc_bits(CW);
    localparam int BW = mul_b_bits(CW);

    logic [DW-1:0] acc_reg, acc_next;
    logic [DW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic [DW-1:0] pp;

    assign pp = a_reg * DW'(b_reg[MAC_DIGIT-1:0]);

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            neg_next  = neg;
            acc_next  = clr ? '0 : acc_reg;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                acc_next = neg_reg ? acc_reg - pp : acc_reg + pp;
                a_next   = a_reg << MAC_DIGIT;
                b_next   = b_reg >> MAC_DIGIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

>>> rtl/tfpr_sqrt.sv
`timescale 1ns / 1ps

module tfpr_sqrt #(
    parameter int CW = tfpr_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*CW+1:0]     v,
    output logic                busy,
    output logic [CW:0]         root
);
    import tfpr_pkg::*;

    localparam int NR = CW + 1;
    localparam int VW = 2 * NR;

    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] res_reg, res_next;
    logic [VW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next    = v;
            res_next  = '0;
            bit_next  = VW'(1) << (VW - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[VW-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            busy_next = !bit_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[NR-1:0];

endmodule

>>> rtl/tfpr_div.sv
`timescale 1ns / 1ps

module tfpr_div #(
    parameter int CW = tfpr_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [CW+8:0]                        num,
    input  logic [CW:0]                          den,
    output logic                                 busy,
    output logic [tfpr_pkg::SCALE_BITS-1:0]      quo
);
    import tfpr_pkg::*;

    localparam int NW = CW + 9;
    localparam int RW = CW + 2;
    localparam int KW = $clog2(SCALE_BITS + 1);

    logic [RW-1:0]         rem_reg, rem_next;
    logic [SCALE_BITS-1:0] low_reg, low_next;
    logic [SCALE_BITS-1:0] quo_reg, quo_next;
    logic [KW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [RW-1:0]         r2;
    logic [CW:0]           num_hi;

    assign num_hi = (CW + 1)'(num[NW-1:SCALE_BITS]);
    assign r2     = {rem_reg[RW-2:0], low_reg[SCALE_BITS-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = RW'(num[NW-1:SCALE_BITS]);
            low_next = num[SCALE_BITS-1:0];
            cnt_next = KW'(SCALE_BITS);
            priority if (den == '0)
            begin
                quo_next = '0;
            end
            else if (num_hi >= den)
            begin
                quo_next = '1;
            end
            else
            begin
                quo_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (r2 >= RW'(den))
            begin
                rem_next = r2 - RW'(den);
                quo_next = {quo_reg[SCALE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = r2;
                quo_next = {quo_reg[SCALE_BITS-2:0], 1'b0};
            end
            low_next  = low_reg << 1;
            cnt_next  = cnt_reg - KW'(1);
            busy_next = (cnt_reg != KW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/two_finger_pinch_recognizer_top.sv
// Events decided at once go from decode straight to write-back; a two-finger start runs the
// MAC and square root, a pinch update adds the divider, the pinch recognition test a chain of MAC steps.
// Throughput: one event at a time; the next is accepted once the current result is registered.
// The long cases are set by the shared multiply-accumulate unit (8 multiplier bits per cycle),
// the 1-bit-pair square root and the 16-step divider.
// Reset (rst_n, async, active low) clears the phase, status, origins and last values to zero.
`timescale 1ns / 1ps

module two_finger_pinch_recognizer_top #(
    parameter int COORD_BITS = tfpr_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 evt_valid,
    output logic                                 evt_ready,
    input  logic [1:0]                           event_type,
    input  logic                                 tiny_move,
    input  logic [3:0]                           touch_count,
    input  logic [15:0]                          first_x,
    input  logic [15:0]                          first_y,
    input  logic [15:0]                          second_x,
    input  logic [15:0]                          second_y,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [2:0]                           action,
    output logic [1:0]                           gesture_phase,
    output logic [tfpr_pkg::SCALE_BITS-1:0]      scale,
    output logic [tfpr_pkg::CENTER_BITS-1:0]     center_x,
    output logic [tfpr_pkg::CENTER_BITS-1:0]     center_y,
    output logic                                 values_valid,
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [tfpr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tfpr_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int CI  = (C < 16) ? C : 16;
    localparam int DW  = acc_bits(C);
    localparam int BW  = mul_b_bits(C);
    localparam int M2W = 2 * C + 1;
    localparam int DQW = 2 * C + 3;
    localparam int SQW = 4 * C + 2;
    localparam int XW  = 2 * C + 33;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_GO     = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_WB     = 3'd6;

    localparam logic [2:0] PH_NONE     = 3'd0;
    localparam logic [2:0] PH_ONE      = 3'd1;
    localparam logic [2:0] PH_TWO      = 3'd2;
    localparam logic [2:0] PH_MOVING   = 3'd3;
    localparam logic [2:0] PH_FINISHED = 3'd4;

    localparam logic [4:0] U_LEN0 = 5'd0;
    localparam logic [4:0] U_LEN1 = 5'd1;
    localparam logic [4:0] U_MA0  = 5'd2;
    localparam logic [4:0] U_MA1  = 5'd3;
    localparam logic [4:0] U_MB0  = 5'd4;
    localparam logic [4:0] U_MB1  = 5'd5;
    localparam logic [4:0] U_AX0  = 5'd6;
    localparam logic [4:0] U_AX1  = 5'd7;
    localparam logic [4:0] U_DA0  = 5'd8;
    localparam logic [4:0] U_DA1  = 5'd9;
    localparam logic [4:0] U_DB0  = 5'd10;
    localparam logic [4:0] U_DB1  = 5'd11;
    localparam logic [4:0] U_MC   = 5'd12;
    localparam logic [4:0] U_SQA  = 5'd13;
    localparam logic [4:0] U_TA   = 5'd14;
    localparam logic [4:0] U_RA   = 5'd15;
    localparam logic [4:0] U_SQB  = 5'd16;
    localparam logic [4:0] U_TB   = 5'd17;
    localparam logic [4:0] U_RB   = 5'd18;

    localparam int DF_LENX = 0;
    localparam int DF_LENY = 1;
    localparam int DF_MAX  = 2;
    localparam int DF_MAY  = 3;
    localparam int DF_MBX  = 4;
    localparam int DF_MBY  = 5;
    localparam int DF_AX   = 6;
    localparam int DF_AY   = 7;
    localparam int NDF     = 8;

    logic [2:0]   state_reg, state_next;
    logic [4:0]   uop_reg, uop_next;
    logic [1:0]   typ_reg, typ_next;
    logic         tiny_reg, tiny_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [C-1:0] p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic [C-1:0] p1x_reg, p1x_next, p1y_reg, p1y_next;

    logic [2:0]   phase_reg, phase_next;
    logic [1:0]   status_reg, status_next;
    logic [C-1:0] ofx_reg, ofx_next, ofy_reg, ofy_next;
    logic [C-1:0] osx_reg, osx_next, osy_reg, osy_next;
    logic [C:0]   od_reg, od_next;
    logic [SCALE_BITS-1:0]  lscale_reg, lscale_next;
    logic [CENTER_BITS-1:0] lcx_reg, lcx_next, lcy_reg, lcy_next;

    logic [15:0]  mc_reg, mc_next;
    logic [31:0]  mm_reg, mm_next;

    logic [2:0]   act_reg, act_next;
    logic         vld_reg, vld_next;
    logic [M2W-1:0] m2a_reg, m2a_next, m2b_reg, m2b_next, a2_reg, a2_next;
    logic [DQW-1:0] d0_reg, d0_next, d1_reg, d1_next;
    logic [31:0]    mc2_reg, mc2_next;
    logic [SQW-1:0] sq_reg, sq_next;

    logic         ov_reg, ov_next;
    logic [2:0]   oact_reg, oact_next;
    logic [1:0]   ostat_reg, ostat_next;
    logic [SCALE_BITS-1:0]  oscale_reg, oscale_next;
    logic [CENTER_BITS-1:0] ocx_reg, ocx_next, ocy_reg, ocy_next;
    logic         ovld_reg, ovld_next;

    logic [C-1:0] pu [NDF];
    logic [C-1:0] pv [NDF];
    logic [C-1:0] dmag [NDF];
    logic [NDF-1:0] dneg;

    logic          mac_start, mac_clr, mac_neg, mac_busy;
    logic [DW-1:0] mac_a, mac_acc;
    logic [BW-1:0] mac_b;
    logic          root_start, root_busy;
    logic [C:0]    root;
    logic          div_start, div_busy;
    logic [SCALE_BITS-1:0] quo;

    logic [DQW-1:0]   d0mag, d1mag, d1v;
    logic             opp, cos_ok, moved_ok;
    logic [SQW+31:0]  lhs;

    always_comb
    begin
        pu[DF_LENX] = p0x_reg;  pv[DF_LENX] = p1x_reg;
        pu[DF_LENY] = p0y_reg;  pv[DF_LENY] = p1y_reg;
        pu[DF_MAX]  = p0x_reg;  pv[DF_MAX]  = ofx_reg;
        pu[DF_MAY]  = p0y_reg;  pv[DF_MAY]  = ofy_reg;
        pu[DF_MBX]  = p1x_reg;  pv[DF_MBX]  = osx_reg;
        pu[DF_MBY]  = p1y_reg;  pv[DF_MBY]  = osy_reg;
        pu[DF_AX]   = ofx_reg;  pv[DF_AX]   = osx_reg;
        pu[DF_AY]   = ofy_reg;  pv[DF_AY]   = osy_reg;
    end

    for (genvar g = 0; g < NDF; g++)
    begin : g_diff
        assign dneg[g] = pu[g] < pv[g];
        assign dmag[g] = dneg[g] ? pv[g] - pu[g] : pu[g] - pv[g];
    end

    assign d0mag = d0_reg[DQW-1] ? DQW'(0) - d0_reg : d0_reg;
    assign d1mag = d1_reg[DQW-1] ? DQW'(0) - d1_reg : d1_reg;
    assign d1v   = mac_acc[DQW-1:0];
    assign opp   = (d0_reg != '0) && (d1v != '0) && (d0_reg[DQW-1] != d1v[DQW-1]);
    assign lhs   = {sq_reg, 32'd0};
    assign cos_ok   = lhs > mac_acc[SQW+31:0];
    assign moved_ok = (XW'(m2a_reg) > XW'(mm_reg)) && (XW'(mac_acc[M2W-1:0]) > XW'(mm_reg));

    // operand select for the shared multiply-accumulate
    always_comb
    begin
        mac_a   = '0;
        mac_b   = '0;
        mac_clr = 1'b1;
        mac_neg = 1'b0;
        unique case (uop_reg)
            U_LEN0:
            begin
                mac_a = DW'(dmag[DF_LENX]); mac_b = BW'(dmag[DF_LENX]);
            end
            U_LEN1:
            begin
                mac_a = DW'(dmag[DF_LENY]); mac_b = BW'(dmag[DF_LENY]); mac_clr = 1'b0;
            end
            U_MA0:
            begin
                mac_a = DW'(dmag[DF_MAX]); mac_b = BW'(dmag[DF_MAX]);
            end
            U_MA1:
            begin
                mac_a = DW'(dmag[DF_MAY]); mac_b = BW'(dmag[DF_MAY]); mac_clr = 1'b0;
            end
            U_MB0:
            begin
                mac_a = DW'(dmag[DF_MBX]); mac_b = BW'(dmag[DF_MBX]);
            end
            U_MB1:
            begin
                mac_a = DW'(dmag[DF_MBY]); mac_b = BW'(dmag[DF_MBY]); mac_clr = 1'b0;
            end
            U_AX0:
            begin
                mac_a = DW'(dmag[DF_AX]); mac_b = BW'(dmag[DF_AX]);
            end
            U_AX1:
            begin
                mac_a = DW'(dmag[DF_AY]); mac_b = BW'(dmag[DF_AY]); mac_clr = 1'b0;
            end
            U_DA0:
            begin
                mac_a   = DW'(dmag[DF_MAX]); mac_b = BW'(dmag[DF_AX]);
                mac_neg = dneg[DF_MAX] ^ dneg[DF_AX];
            end
            U_DA1:
            begin
                mac_a   = DW'(dmag[DF_MAY]); mac_b = BW'(dmag[DF_AY]);
                mac_neg = dneg[DF_MAY] ^ dneg[DF_AY]; mac_clr = 1'b0;
            end
            U_DB0:
            begin
                mac_a   = DW'(dmag[DF_MBX]); mac_b = BW'(dmag[DF_AX]);
                mac_neg = dneg[DF_MBX] ^ dneg[DF_AX];
            end
            U_DB1:
            begin
                mac_a   = DW'(dmag[DF_MBY]); mac_b = BW'(dmag[DF_AY]);
                mac_neg = dneg[DF_MBY] ^ dneg[DF_AY]; mac_clr = 1'b0;
            end
            U_MC:
            begin
                mac_a = DW'(mc_reg); mac_b = BW'(mc_reg);
            end
            U_SQA:
            begin
                mac_a = DW'(d0mag); mac_b = BW'(d0mag);
            end
            U_TA:
            begin
                mac_a = DW'(m2a_reg); mac_b = BW'(a2_reg);
            end
            U_SQB:
            begin
                mac_a = DW'(d1mag); mac_b = BW'(d1mag);
            end
            U_TB:
            begin
                mac_a = DW'(m2b_reg); mac_b = BW'(a2_reg);
            end
            U_RA, U_RB:
            begin
                mac_a = mac_acc; mac_b = BW'(mc2_reg);
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        uop_next    = uop_reg;
        typ_next    = typ_reg;
        tiny_next   = tiny_reg;
        cnt_next    = cnt_reg;
        p0x_next    = p0x_reg;
        p0y_next    = p0y_reg;
        p1x_next    = p1x_reg;
        p1y_next    = p1y_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        ofx_next    = ofx_reg;
        ofy_next    = ofy_reg;
        osx_next    = osx_reg;
        osy_next    = osy_reg;
        od_next     = od_reg;
        lscale_next = lscale_reg;
        lcx_next    = lcx_reg;
        lcy_next    = lcy_reg;
        mc_next     = mc_reg;
        mm_next     = mm_reg;
        act_next    = act_reg;
        vld_next    = vld_reg;
        m2a_next    = m2a_reg;
        m2b_next    = m2b_reg;
        a2_next     = a2_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        mc2_next    = mc2_reg;
        sq_next     = sq_reg;
        ov_next     = ov_reg && !res_ready;
        oact_next   = oact_reg;
        ostat_next  = ostat_reg;
        oscale_next = oscale_reg;
        ocx_next    = ocx_reg;
        ocy_next    = ocy_reg;
        ovld_next   = ovld_reg;
        evt_ready   = 1'b0;
        mac_start   = 1'b0;
        root_start  = 1'b0;
        div_start   = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_COSINE: mc_next = cfg_data[15:0];
                CFG_MIN_MOVE:   mm_next = cfg_data[31:0];
                default:        mm_next = mm_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    typ_next   = event_type;
                    tiny_next  = tiny_move;
                    cnt_next   = touch_count;
                    p0x_next   = C'(first_x[CI-1:0]);
                    p0y_next   = C'(first_y[CI-1:0]);
                    p1x_next   = C'(second_x[CI-1:0]);
                    p1y_next   = C'(second_y[CI-1:0]);
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                vld_next   = 1'b0;
                state_next = S_WB;
                if (phase_reg == PH_NONE || phase_reg == PH_ONE)
                begin
                    priority if (typ_reg == EV_MOVE && tiny_reg)
                    begin
                        act_next = ACT_IGNORE;
                    end
                    else if (typ_reg != EV_START || cnt_reg > 4'd2)
                    begin
                        act_next = ACT_CANCEL;
                    end
                    else if (cnt_reg == 4'd2)
                    begin
                        act_next   = ACT_MAYBE;
                        ofx_next   = p0x_reg;
                        ofy_next   = p0y_reg;
                        osx_next   = p1x_reg;
                        osy_next   = p1y_reg;
                        uop_next   = U_LEN0;
                        state_next = S_GO;
                    end
                    else
                    begin
                        act_next = ACT_MAYBE;
                        if (cnt_reg == 4'd1)
                        begin
                            phase_next = PH_ONE;
                        end
                    end
                end
                else if ((phase_reg == PH_TWO || phase_reg == PH_MOVING) && typ_reg == EV_MOVE)
                begin
                    uop_next   = (phase_reg == PH_TWO) ? U_MA0 : U_LEN0;
                    state_next = S_GO;
                end
                else if (phase_reg == PH_TWO || phase_reg == PH_MOVING)
                begin
                    phase_next  = PH_FINISHED;
                    status_next = GS_FINISHED;
                    act_next    = ACT_FINISH;
                end
                else
                begin
                    act_next = ACT_FINISH;
                end
            end
            S_GO:
            begin
                mac_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!mac_busy)
                begin
                    uop_next   = uop_reg + 5'd1;
                    state_next = S_GO;
                    unique case (uop_reg)
                        U_LEN1:
                        begin
                            root_start = 1'b1;
                            state_next = S_ROOT;
                        end
                        U_MA1:
                        begin
                            m2a_next = mac_acc[M2W-1:0];
                        end
                        U_MB1:
                        begin
                            m2b_next = mac_acc[M2W-1:0];
                            if (!moved_ok)
                            begin
                                act_next   = ACT_MAYBE;
                                state_next = S_WB;
                            end
                        end
                        U_AX1:
                        begin
                            a2_next = mac_acc[M2W-1:0];
                        end
                        U_DA1:
                        begin
                            d0_next = mac_acc[DQW-1:0];
                        end
                        U_DB1:
                        begin
                            d1_next = d1v;
                            if (!opp)
                            begin
                                act_next   = ACT_CANCEL;
                                state_next = S_WB;
                            end
                        end
                        U_MC:
                        begin
                            mc2_next = mac_acc[31:0];
                        end
                        U_SQA, U_SQB:
                        begin
                            sq_next = mac_acc[SQW-1:0];
                        end
                        U_RA:
                        begin
                            if (!cos_ok)
                            begin
                                act_next   = ACT_CANCEL;
                                state_next = S_WB;
                            end
                        end
                        U_RB:
                        begin
                            state_next = S_WB;
                            if (!cos_ok)
                            begin
                                act_next = ACT_CANCEL;
                            end
                            else
                            begin
                                act_next    = ACT_TRIGGER;
                                status_next = GS_STARTED;
                                phase_next  = PH_MOVING;
                            end
                        end
                        default:
                        begin
                            state_next = S_GO;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                if (!root_busy)
                begin
                    if (phase_reg == PH_MOVING)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        od_next    = root;
                        phase_next = PH_TWO;
                        act_next   = ACT_MAYBE;
                        state_next = S_WB;
                    end
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    lscale_next = quo;
                    lcx_next    = CENTER_BITS'((C + 1)'(p0x_reg) + (C + 1)'(p1x_reg));
                    lcy_next    = CENTER_BITS'((C + 1)'(p0y_reg) + (C + 1)'(p1y_reg));
                    status_next = GS_UPDATED;
                    vld_next    = 1'b1;
                    act_next    = ACT_TRIGGER;
                    state_next  = S_WB;
                end
            end
            S_WB:
            begin
                if (!ov_reg || res_ready)
                begin
                    ov_next     = 1'b1;
                    oact_next   = act_reg;
                    ostat_next  = status_reg;
                    oscale_next = lscale_reg;
                    ocx_next    = lcx_reg;
                    ocy_next    = lcy_reg;
                    ovld_next   = vld_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_NONE;
            status_reg <= GS_NONE;
            ofx_reg    <= '0;
            ofy_reg    <= '0;
            osx_reg    <= '0;
            osy_reg    <= '0;
            od_reg     <= '0;
            lscale_reg <= '0;
            lcx_reg    <= '0;
            lcy_reg    <= '0;
            mc_reg     <= MIN_COSINE_RST;
            mm_reg     <= MIN_MOVE_RST;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
            ofx_reg    <= ofx_next;
            ofy_reg    <= ofy_next;
            osx_reg    <= osx_next;
            osy_reg    <= osy_next;
            od_reg     <= od_next;
            lscale_reg <= lscale_next;
            lcx_reg    <= lcx_next;
            lcy_reg    <= lcy_next;
            mc_reg     <= mc_next;
            mm_reg     <= mm_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uop_reg    <= uop_next;
        typ_reg    <= typ_next;
        tiny_reg   <= tiny_next;
        cnt_reg    <= cnt_next;
        p0x_reg    <= p0x_next;
        p0y_reg    <= p0y_next;
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        act_reg    <= act_next;
        vld_reg    <= vld_next;
        m2a_reg    <= m2a_next;
        m2b_reg    <= m2b_next;
        a2_reg     <= a2_next;
        d0_reg     <= d0_next;
        d1_reg     <= d1_next;
        mc2_reg    <= mc2_next;
        sq_reg     <= sq_next;
        oact_reg   <= oact_next;
        ostat_reg  <= ostat_next;
        oscale_reg <= oscale_next;
        ocx_reg    <= ocx_next;
        ocy_reg    <= ocy_next;
        ovld_reg   <= ovld_next;
    end

    tfpr_mac #(.CW(C)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .clr   (mac_clr),
        .neg   (mac_neg),
        .a     (mac_a),
        .b     (mac_b),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    tfpr_sqrt #(.CW(C)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .v     (mac_acc[2*C+1:0]),
        .busy  (root_busy),
        .root  (root)
    );

    tfpr_div #(.CW(C)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({root, 8'd0}),
        .den   (od_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign res_valid     = ov_reg;
    assign action        = oact_reg;
    assign gesture_phase = ostat_reg;
    assign scale         = oscale_reg;
    assign center_x      = ocx_reg;
    assign center_y      = ocy_reg;
    assign values_valid  = ovld_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        evt_ready |-> !(mac_busy || root_busy || div_busy))
        else $error("event taken while a unit is busy");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mac_busy, root_busy, div_busy}))
        else $error("more than one arithmetic unit busy");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FINISHED |=> phase_reg == PH_FINISHED)
        else $error("left finished phase without reset");

    a_values_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && values_valid |-> action == ACT_TRIGGER && gesture_phase == GS_UPDATED)
        else $error("value update without an updated trigger");
`endif

endmodule
